// ===== hdl/t0pbh_pkg.sv =====
// Types and constants for the T=0 procedure byte handler.
package t0pbh_pkg;

    localparam int MAX_RESPONSE_DEF = 258;
    localparam logic [7:0] NULL_LIMIT_RESET = 8'd200;

    localparam logic [7:0] NULL_BYTE = 8'h60;
    localparam logic [3:0] SW1_NIB_6 = 4'h6;
    localparam logic [3:0] SW1_NIB_9 = 4'h9;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_BYTE     = 2'd1,
        CMD_LINK_ERR = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SEND_REM  = 3'd1,
        ACT_SEND_ONE  = 3'd2,
        ACT_DATA      = 3'd3,
        ACT_DONE      = 3'd4,
        ACT_PROTO_ERR = 3'd5,
        ACT_NULL_LIM  = 3'd6,
        ACT_LINK_ERR  = 3'd7
    } act_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PROC = 4'b0010,
        PH_DATA = 4'b0100,
        PH_SW2  = 4'b1000
    } phase_t;

    typedef struct packed {
        act_t       action;
        logic [7:0] tx_count;
        logic [7:0] tx_offset;
        logic [8:0] data_index;
        logic [7:0] data_byte;
        logic [7:0] sw1;
        logic [7:0] sw2;
        logic [8:0] resp_len;
    } result_t;

endpackage

// ===== hdl/t0_procedure_byte_handler_core.sv =====
// T=0 procedure byte handler: per-word classification, exchange state and result register.
// A result word is registered and appears on m_axis in the cycle after its input word is accepted.
// Throughput: one word per cycle; a new word is taken in the same cycle the pending result
// is read, so s_axis_tready drops only while the result register is full and stalled.
// Reset (aresetn low, synchronous): exchange idle, all counters and latched header cleared,
// null_limit back to 200, no result pending.
module t0_procedure_byte_handler_core #(
    parameter int MAX_RESPONSE = t0pbh_pkg::MAX_RESPONSE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [7:0]                        cfg_wr_data,   // null_limit
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // ins[7:0], outgoing[8], lc[16:9], le[25:17], rx_byte[33:26], zero pad
    input  logic [t0pbh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [t0pbh_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tx_count[7:0], tx_offset[15:8], data_index[24:16], data_byte[32:25],
    // sw1[40:33], sw2[48:41], resp_len[57:49], zero pad
    output logic [t0pbh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // action[2:0]
    output logic [t0pbh_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import t0pbh_pkg::*;

    // receive counter must hold MAX_RESPONSE and a full 9-bit Le
    localparam int CLOG_W = $clog2(MAX_RESPONSE + 1);
    localparam int CNT_W  = (CLOG_W < 10) ? 10 : CLOG_W;
    localparam logic [CNT_W-1:0] ROOM = CNT_W'(MAX_RESPONSE - 2);

    logic [7:0]       null_limit_reg;
    phase_t           phase_reg, phase_next;
    logic [7:0]       null_count_reg, null_count_next;
    logic [7:0]       sent_count_reg, sent_count_next;
    logic [CNT_W-1:0] recv_count_reg, recv_count_next;
    logic [CNT_W-1:0] recv_target_reg, recv_target_next;
    logic [7:0]       ins_reg, ins_next;
    logic             dir_reg, dir_next;
    logic [7:0]       lc_reg, lc_next;
    logic [CNT_W-1:0] le_reg, le_next;
    logic [7:0]       sw1_reg, sw1_next;
    result_t          res_reg, res_next;
    logic             m_valid_reg;

    cmd_t             in_cmd;
    logic [7:0]       in_ins;
    logic             in_outgoing;
    logic [7:0]       in_lc;
    logic [CNT_W-1:0] in_le;
    logic [7:0]       in_byte;
    logic             in_acc;
    logic [7:0]       null_inc;
    logic [CNT_W-1:0] recv_inc;
    logic             is_ack;
    logic             is_nack;

    assign in_cmd      = cmd_t'(s_axis_tuser[1:0]);
    assign in_ins      = s_axis_tdata[7:0];
    assign in_outgoing = s_axis_tdata[8];
    assign in_lc       = s_axis_tdata[16:9];
    assign in_le       = {{(CNT_W-9){1'b0}}, s_axis_tdata[25:17]};
    assign in_byte     = s_axis_tdata[33:26];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign null_inc = (null_count_reg != 8'hFF) ? null_count_reg + 8'd1 : null_count_reg;
    assign recv_inc = recv_count_reg + CNT_W'(1);
    // ACK matches INS bits 3..1, inverted ACK matches them complemented
    assign is_ack   = (in_byte[3:1] == ins_reg[3:1]);
    assign is_nack  = (in_byte[3:1] == ~ins_reg[3:1]);

    always_comb begin
        phase_next       = phase_reg;
        null_count_next  = null_count_reg;
        sent_count_next  = sent_count_reg;
        recv_count_next  = recv_count_reg;
        recv_target_next = recv_target_reg;
        ins_next         = ins_reg;
        dir_next         = dir_reg;
        lc_next          = lc_reg;
        le_next          = le_reg;
        sw1_next         = sw1_reg;
        res_next         = '0;
        res_next.action  = ACT_NONE;

        case (in_cmd)
            CMD_START: begin
                ins_next         = in_ins;
                dir_next         = in_outgoing;
                lc_next          = in_lc;
                le_next          = (in_le > ROOM) ? ROOM : in_le;
                null_count_next  = '0;
                sent_count_next  = '0;
                recv_count_next  = '0;
                recv_target_next = '0;
                sw1_next         = '0;
                phase_next       = PH_PROC;
            end
            CMD_LINK_ERR: begin
                if (phase_reg != PH_IDLE) begin
                    phase_next      = PH_IDLE;
                    res_next.action = ACT_LINK_ERR;
                end
            end
            CMD_BYTE: begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_PROC: begin
                        if (in_byte == NULL_BYTE) begin
                            null_count_next = null_inc;
                            if (null_inc >= null_limit_reg) begin
                                phase_next      = PH_IDLE;
                                res_next.action = ACT_NULL_LIM;
                            end
                        end else if (in_byte[7:4] == SW1_NIB_6 ||
                                     in_byte[7:4] == SW1_NIB_9) begin
                            sw1_next        = in_byte;
                            recv_count_next = recv_inc;
                            phase_next      = PH_SW2;
                        end else if (!is_ack && !is_nack) begin
                            phase_next      = PH_IDLE;
                            res_next.action = ACT_PROTO_ERR;
                        end else begin
                            null_count_next = '0;
                            if (dir_reg) begin
                                if (sent_count_reg >= lc_reg) begin
                                    phase_next      = PH_IDLE;
                                    res_next.action = ACT_PROTO_ERR;
                                end else if (is_ack) begin
                                    sent_count_next    = lc_reg;
                                    res_next.action    = ACT_SEND_REM;
                                    res_next.tx_count  = lc_reg - sent_count_reg;
                                    res_next.tx_offset = sent_count_reg;
                                end else begin
                                    sent_count_next    = sent_count_reg + 8'd1;
                                    res_next.action    = ACT_SEND_ONE;
                                    res_next.tx_count  = 8'd1;
                                    res_next.tx_offset = sent_count_reg;
                                end
                            end else if (recv_count_reg >= ROOM) begin
                                phase_next      = PH_IDLE;
                                res_next.action = ACT_PROTO_ERR;
                            end else if (is_ack) begin
                                // nothing left to receive when Le is already reached
                                if (le_reg > recv_count_reg) begin
                                    recv_target_next = le_reg;
                                    phase_next       = PH_DATA;
                                end
                            end else begin
                                recv_target_next = recv_inc;
                                phase_next       = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        recv_count_next     = recv_inc;
                        if (recv_inc >= recv_target_reg) begin
                            phase_next = PH_PROC;
                        end
                        res_next.action     = ACT_DATA;
                        res_next.data_index = recv_count_reg[8:0];
                        res_next.data_byte  = in_byte;
                    end
                    PH_SW2: begin
                        phase_next        = PH_IDLE;
                        res_next.action   = ACT_DONE;
                        res_next.sw1      = sw1_reg;
                        res_next.sw2      = in_byte;
                        res_next.resp_len = recv_inc[8:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            null_limit_reg  <= NULL_LIMIT_RESET;
            m_valid_reg     <= 1'b0;
            phase_reg       <= PH_IDLE;
            null_count_reg  <= '0;
            sent_count_reg  <= '0;
            recv_count_reg  <= '0;
            recv_target_reg <= '0;
            ins_reg         <= '0;
            dir_reg         <= 1'b0;
            lc_reg          <= '0;
            le_reg          <= '0;
            sw1_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                null_limit_reg <= cfg_wr_data;
            end
            if (s_axis_tready) begin
                m_valid_reg <= s_axis_tvalid;
            end
            if (in_acc) begin
                phase_reg       <= phase_next;
                null_count_reg  <= null_count_next;
                sent_count_reg  <= sent_count_next;
                recv_count_reg  <= recv_count_next;
                recv_target_reg <= recv_target_next;
                ins_reg         <= ins_next;
                dir_reg         <= dir_next;
                lc_reg          <= lc_next;
                le_reg          <= le_next;
                sw1_reg         <= sw1_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.action;
    assign m_axis_tdata  = {6'd0, res_reg.resp_len, res_reg.sw2, res_reg.sw1,
                            res_reg.data_byte, res_reg.data_index,
                            res_reg.tx_offset, res_reg.tx_count};

endmodule
